// File: design/mit_command_quantize_pack_core_macros.svh
// assertion macros shared by the command quantize and pack block
`ifndef MIT_COMMAND_QUANTIZE_PACK_CORE_MACROS_SVH
`define MIT_COMMAND_QUANTIZE_PACK_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define MCQP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mcqp same-cycle check failed");

// next-cycle implication, sampled on clock, off during reset
`define MCQP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mcqp next-cycle check failed");

`endif

// File: design/mcqp_pkg.sv
// shared types, constants and helper functions for the command quantize and pack block
`default_nettype none

package mcqp_pkg;

   // value lanes, in input field order
   localparam int LANES        = 5;
   localparam int LANE_POS     = 0;
   localparam int LANE_SPEED   = 1;
   localparam int LANE_TORQUE  = 2;
   localparam int LANE_STIFF   = 3;
   localparam int LANE_DAMP    = 4;
   localparam int SIGNED_LANES = 3;

   // widths
   localparam int VAL_W       = 32;
   localparam int GAIN_W      = 31;
   localparam int POS_BITS    = 16;
   localparam int CMD_BITS    = 12;
   localparam int QUO_W       = 16;
   localparam int NUM_W       = VAL_W + QUO_W;
   localparam int DIV_STEPS   = QUO_W;
   localparam int REQ_DATA_W  = LANES * VAL_W;
   localparam int RSP_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;

   // pipeline layout: input, clamp, offset, numerator, divide steps, output
   localparam int FRONT_STAGES = 4;
   localparam int STAGES       = FRONT_STAGES + DIV_STEPS + 1;

   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic [VAL_W-1:0]        span_type;
   typedef logic [QUO_W-1:0]        quot_type;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POSITION_LOW   = 3'd0,
      CSR_POSITION_HIGH  = 3'd1,
      CSR_SPEED_LOW      = 3'd2,
      CSR_SPEED_HIGH     = 3'd3,
      CSR_TORQUE_LOW     = 3'd4,
      CSR_TORQUE_HIGH    = 3'd5,
      CSR_STIFFNESS_HIGH = 3'd6,
      CSR_DAMPING_HIGH   = 3'd7
   } csr_index_type;

   // register reset values
   localparam value_type          POS_LOW_RESET    = -32'sd32768;
   localparam value_type          POS_HIGH_RESET   = 32'sd32768;
   localparam value_type          SPEED_LOW_RESET  = -32'sd655360;
   localparam value_type          SPEED_HIGH_RESET = 32'sd655360;
   localparam value_type          TORQUE_LOW_RESET = -32'sd655360;
   localparam value_type          TORQUE_HIGH_RESET = 32'sd655360;
   localparam logic [GAIN_W-1:0] STIFF_HIGH_RESET = 31'd6553600;
   localparam logic [GAIN_W-1:0] DAMP_HIGH_RESET  = 31'd1310720;

   // load enables for the divide stages
   typedef struct packed {
      logic [DIV_STEPS-1:0] load;
   } div_ctl_type;

   // code width of a lane
   function automatic int lane_bits(input int lane);
      return (lane == LANE_POS) ? POS_BITS : CMD_BITS;
   endfunction

   // one restoring division step: {quotient bit, next remainder}
   function automatic logic [VAL_W:0] div_step(input logic [VAL_W-1:0] rem,
                                               input logic [VAL_W-1:0] span,
                                               input logic nbit);
      logic [VAL_W:0] trial;
      logic [VAL_W:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, span};
      if (trial >= {1'b0, span}) begin
         return {1'b1, diff[VAL_W-1:0]};
      end
      return {1'b0, trial[VAL_W-1:0]};
   endfunction

endpackage

`default_nettype wire

// File: design/mcqp_divider.sv
// pipelined restoring divider, one quotient bit per stage, five lanes side by side
`default_nettype none

module mcqp_divider (
   input  logic                                                 clock,
   input  mcqp_pkg::div_ctl_type                                div_ctl,
   input  logic [mcqp_pkg::LANES-1:0][mcqp_pkg::VAL_W-1:0]     span,
   input  logic [mcqp_pkg::LANES-1:0][mcqp_pkg::VAL_W-1:0]     rem_init,
   input  logic [mcqp_pkg::LANES-1:0][mcqp_pkg::QUO_W-1:0]     nq_init,
   input  logic [mcqp_pkg::LANES-1:0]                           bad_init,
   output logic [mcqp_pkg::LANES-1:0][mcqp_pkg::QUO_W-1:0]     quotient,
   output logic [mcqp_pkg::LANES-1:0]                           bad
);
   import mcqp_pkg::*;

   // per stage: partial remainder, numerator bits / quotient shift word, span fault
   logic [LANES-1:0][VAL_W-1:0] rem_ff [DIV_STEPS];
   logic [LANES-1:0][QUO_W-1:0] nq_ff  [DIV_STEPS];
   logic [LANES-1:0]            bad_ff [DIV_STEPS];

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [LANES-1:0][VAL_W-1:0] src_rem;
      logic [LANES-1:0][QUO_W-1:0] src_nq;
      logic [LANES-1:0]            src_bad;
      logic [LANES-1:0][VAL_W-1:0] rem_in;
      logic [LANES-1:0][QUO_W-1:0] nq_in;

      // stage source: numerator stage or previous divide stage
      if (s == 0) begin : g_first
         assign src_rem = rem_init;
         assign src_nq  = nq_init;
         assign src_bad = bad_init;
      end else begin : g_next
         assign src_rem = rem_ff[s-1];
         assign src_nq  = nq_ff[s-1];
         assign src_bad = bad_ff[s-1];
      end

      // bring down the next numerator bit, shift in the quotient bit
      always_comb begin
         logic [VAL_W:0] res;
         for (int l = 0; l < LANES; l++) begin
            res       = div_step(src_rem[l], span[l], src_nq[l][QUO_W-1]);
            rem_in[l] = res[VAL_W-1:0];
            nq_in[l]  = {src_nq[l][QUO_W-2:0], res[VAL_W]};
         end
      end

      // stage register
      always_ff @(posedge clock) begin
         if (div_ctl.load[s]) begin
            rem_ff[s] <= rem_in;
            nq_ff[s]  <= nq_in;
            bad_ff[s] <= src_bad;
         end
      end
   end

   // after the last step the shift word holds the quotient
   assign quotient = nq_ff[DIV_STEPS-1];
   assign bad      = bad_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

// File: design/mit_command_quantize_pack_core.sv
// top level: clamps, quantizes and packs one impedance-control motor command per transaction
//
//   channel | direction | handshake           | contents
//   req     | in        | req_tvalid/tready   | five Q16.16 command values
//   rsp     | out       | rsp_tvalid/tready   | 64-bit command word, span fault flag
//   csr     | in        | csr_valid/ready     | register index, write data
//
// one transaction per cycle sustained while rsp_tready stays high; a result is offered
// through 21 register stages: input, clamp, offset, numerator, 16 divider steps, output.
// synchronous reset clears valid bits and loads register defaults; no clearing pass.
// each stage holds only while the stage after it is full and stalled, so bubbles
// collapse and new transactions enter while a finished result waits on rsp_tready.
`default_nettype none
`include "mit_command_quantize_pack_core_macros.svh"

module mit_command_quantize_pack_core (
   input  logic                                clock,
   input  logic                                reset,
   // target_position, target_speed, feedforward_torque, stiffness_gain, damping_gain
   input  logic [mcqp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // packed_payload
   output logic [mcqp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // range_fault
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcqp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mcqp_pkg::VAL_W-1:0]          csr_data
);
   import mcqp_pkg::*;

   // configuration registers
   value_type          cfg_low_ff  [SIGNED_LANES];
   value_type          cfg_high_ff [SIGNED_LANES];
   logic [GAIN_W-1:0]  stiff_high_ff;
   logic [GAIN_W-1:0]  damp_high_ff;

   // per-lane range and derived span / fault
   value_type          lo_w [LANES];
   value_type          hi_w [LANES];
   span_type           span_in  [LANES];
   logic [LANES-1:0]   fault_in;
   logic [LANES-1:0][VAL_W-1:0] span_ff;
   logic [LANES-1:0]   fault_ff;

   // pipeline control
   logic [STAGES-1:0]  valid_ff;
   logic [STAGES-1:0]  en;
   div_ctl_type        div_ctl;

   // front stages
   value_type          in_val_ff [LANES];
   value_type          clamp_in  [LANES];
   value_type          clamp_ff  [LANES];
   logic [LANES-1:0]   bad1_ff;
   span_type           off_in    [LANES];
   span_type           off_ff    [LANES];
   logic [LANES-1:0]   bad2_ff;
   logic [LANES-1:0][VAL_W-1:0] rem_in;
   logic [LANES-1:0][QUO_W-1:0] nq_in;
   logic [LANES-1:0][VAL_W-1:0] rem_ff;
   logic [LANES-1:0][QUO_W-1:0] nq_ff;
   logic [LANES-1:0]   bad3_ff;

   // divider outputs and output stage
   logic [LANES-1:0][QUO_W-1:0] quot_w;
   logic [LANES-1:0]   bad_w;
   quot_type           code_w [LANES];
   logic [RSP_DATA_W-1:0] payload_in;
   logic [RSP_DATA_W-1:0] payload_ff;
   logic [LANES-1:0]   out_bad_ff;
   logic               pos_code_zero;

   // register writes
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_low_ff[LANE_POS]     <= POS_LOW_RESET;
         cfg_high_ff[LANE_POS]    <= POS_HIGH_RESET;
         cfg_low_ff[LANE_SPEED]   <= SPEED_LOW_RESET;
         cfg_high_ff[LANE_SPEED]  <= SPEED_HIGH_RESET;
         cfg_low_ff[LANE_TORQUE]  <= TORQUE_LOW_RESET;
         cfg_high_ff[LANE_TORQUE] <= TORQUE_HIGH_RESET;
         stiff_high_ff            <= STIFF_HIGH_RESET;
         damp_high_ff             <= DAMP_HIGH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_POSITION_LOW:   cfg_low_ff[LANE_POS]     <= value_type'(csr_data);
            CSR_POSITION_HIGH:  cfg_high_ff[LANE_POS]    <= value_type'(csr_data);
            CSR_SPEED_LOW:      cfg_low_ff[LANE_SPEED]   <= value_type'(csr_data);
            CSR_SPEED_HIGH:     cfg_high_ff[LANE_SPEED]  <= value_type'(csr_data);
            CSR_TORQUE_LOW:     cfg_low_ff[LANE_TORQUE]  <= value_type'(csr_data);
            CSR_TORQUE_HIGH:    cfg_high_ff[LANE_TORQUE] <= value_type'(csr_data);
            CSR_STIFFNESS_HIGH: stiff_high_ff            <= csr_data[GAIN_W-1:0];
            CSR_DAMPING_HIGH:   damp_high_ff             <= csr_data[GAIN_W-1:0];
            default:            ;
         endcase
      end
   end

   // lane ranges; gain minimums are zero
   always_comb begin
      for (int l = 0; l < SIGNED_LANES; l++) begin
         lo_w[l] = cfg_low_ff[l];
         hi_w[l] = cfg_high_ff[l];
      end
      lo_w[LANE_STIFF] = '0;
      hi_w[LANE_STIFF] = value_type'({1'b0, stiff_high_ff});
      lo_w[LANE_DAMP]  = '0;
      hi_w[LANE_DAMP]  = value_type'({1'b0, damp_high_ff});
   end

   // span and empty-span fault, refreshed every cycle from the registers
   always_comb begin
      logic [VAL_W:0] diff;
      for (int l = 0; l < LANES; l++) begin
         diff        = {hi_w[l][VAL_W-1], hi_w[l]} - {lo_w[l][VAL_W-1], lo_w[l]};
         span_in[l]  = diff[VAL_W-1:0];
         fault_in[l] = (hi_w[l] <= lo_w[l]);
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         span_ff[l] <= span_in[l];
      end
      fault_ff <= fault_in;
   end

   // stage enables: a stage moves when empty or when the next one moves
   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_tready   = en[0] && !reset;
   assign div_ctl.load = en[FRONT_STAGES +: DIV_STEPS];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // stage 0: capture the command values
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int l = 0; l < LANES; l++) begin
            in_val_ff[l] <= value_type'(req_tdata[l*VAL_W +: VAL_W]);
         end
      end
   end

   // stage 1: clamp to the lane range
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (in_val_ff[l] < lo_w[l]) begin
            clamp_in[l] = lo_w[l];
         end else if (in_val_ff[l] > hi_w[l]) begin
            clamp_in[l] = hi_w[l];
         end else begin
            clamp_in[l] = in_val_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         clamp_ff <= clamp_in;
         bad1_ff  <= fault_ff;
      end
   end

   // stage 2: offset from the range minimum, zero on an empty span
   always_comb begin
      logic [VAL_W:0] diff;
      for (int l = 0; l < LANES; l++) begin
         diff      = {clamp_ff[l][VAL_W-1], clamp_ff[l]} - {lo_w[l][VAL_W-1], lo_w[l]};
         off_in[l] = bad1_ff[l] ? '0 : diff[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         off_ff  <= off_in;
         bad2_ff <= bad1_ff;
      end
   end

   // stage 3: numerator off * (2^bits - 1), split into initial remainder and low bits
   always_comb begin
      logic [NUM_W-1:0] off_x;
      logic [NUM_W-1:0] num;
      for (int l = 0; l < LANES; l++) begin
         off_x     = {{QUO_W{1'b0}}, off_ff[l]};
         num       = (off_x << lane_bits(l)) - off_x;
         rem_in[l] = num[NUM_W-1:QUO_W];
         nq_in[l]  = num[QUO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
         bad3_ff <= bad2_ff;
      end
   end

   // stages 4 to 19: one quotient bit per stage
   mcqp_divider u_divider (
      .clock    (clock),
      .div_ctl  (div_ctl),
      .span     (span_ff),
      .rem_init (rem_ff),
      .nq_init  (nq_ff),
      .bad_init (bad3_ff),
      .quotient (quot_w),
      .bad      (bad_w)
   );

   // output stage: mask faulted lanes and pack torque, damping, stiffness, velocity, position
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         code_w[l] = bad_w[l] ? '0 : quot_w[l];
      end
      payload_in = {code_w[LANE_POS][POS_BITS-1:0],
                    code_w[LANE_SPEED][CMD_BITS-1:0],
                    code_w[LANE_STIFF][CMD_BITS-1:0],
                    code_w[LANE_DAMP][CMD_BITS-1:0],
                    code_w[LANE_TORQUE][CMD_BITS-1:0]};
   end

   always_ff @(posedge clock) begin
      if (en[STAGES-1]) begin
         payload_ff <= payload_in;
         out_bad_ff <= bad_w;
      end
   end

   assign rsp_tdata  = payload_ff;
   assign rsp_tuser  = |out_bad_ff;
   assign rsp_tvalid = valid_ff[STAGES-1];

   // position code field of the presented word
   assign pos_code_zero = (rsp_tdata[RSP_DATA_W-1 -: POS_BITS] == '0);

   // a draining output keeps the whole pipeline moving
   `MCQP_ASSERT_IMPL(a_drain_accepts, rsp_tready, req_tready)
   // a stalled divider entry stage keeps its transaction
   `MCQP_ASSERT_NEXT(a_div_hold, valid_ff[FRONT_STAGES] && !en[FRONT_STAGES], valid_ff[FRONT_STAGES])
   // an empty position span gives a zero position code and the fault flag
   `MCQP_ASSERT_IMPL(a_pos_fault_zero, rsp_tvalid && out_bad_ff[LANE_POS], pos_code_zero && rsp_tuser)

endmodule

`default_nettype wire

// File: bench/tb_mit_command_quantize_pack_core.sv
// self-checking testbench for the motor command quantize and pack block
`timescale 1ns / 100ps

module tb_mit_command_quantize_pack_core;
   import mcqp_pkg::*;

   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 127;
   localparam int IDLE_PERCENT    = 22;

   // one expected command word
   typedef struct packed {
      logic [RSP_DATA_W-1:0] payload;
      logic                  fault;
   } command_word_type;

   // one full set of range registers, as written on the csr channel
   typedef struct {
      logic [VAL_W-1:0] pos_low;
      logic [VAL_W-1:0] pos_high;
      logic [VAL_W-1:0] speed_low;
      logic [VAL_W-1:0] speed_high;
      logic [VAL_W-1:0] torque_low;
      logic [VAL_W-1:0] torque_high;
      logic [VAL_W-1:0] stiff_high;
      logic [VAL_W-1:0] damp_high;
   } limit_set_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [VAL_W-1:0]        csr_data = '0;

   // range registers as the block should hold them now
   limit_set_type active_limits = '{
      POS_LOW_RESET, POS_HIGH_RESET, SPEED_LOW_RESET, SPEED_HIGH_RESET,
      TORQUE_LOW_RESET, TORQUE_HIGH_RESET,
      {1'b0, STIFF_HIGH_RESET}, {1'b0, DAMP_HIGH_RESET}};

   command_word_type expected_words[$];
   logic          steady_run = 1'b0;
   int            mismatch_count = 0;
   int            commands_sent = 0;
   int            words_checked = 0;
   int            csr_writes = 0;
   int            range_sets = 0;
   int            idle_cycles = 0;

   mit_command_quantize_pack_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // clamp one value to [lo, hi] and scale it to a code of the given width
   function automatic logic [POS_BITS-1:0] lane_code(input value_type v, input value_type lo,
                                                     input value_type hi, input int bits,
                                                     inout logic fault);
      longint          v_l;
      longint          lo_l;
      longint          hi_l;
      longint unsigned offset;
      longint unsigned span;
      longint unsigned full;
      v_l  = longint'(v);
      lo_l = longint'(lo);
      hi_l = longint'(hi);
      if (hi_l <= lo_l) begin
         fault = 1'b1;
         return '0;
      end
      if (v_l < lo_l) v_l = lo_l;
      else if (v_l > hi_l) v_l = hi_l;
      offset = v_l - lo_l;
      span   = hi_l - lo_l;
      full   = (64'd1 << bits) - 64'd1;
      return POS_BITS'((offset * full) / span);
   endfunction

   // expected command word for one command under the active ranges
   function automatic command_word_type predict_command(input value_type pos, input value_type spd,
                                                        input value_type trq, input value_type kp,
                                                        input value_type kd);
      command_word_type    word;
      logic                fault;
      logic [POS_BITS-1:0] pos_c, spd_c, trq_c, kp_c, kd_c;
      fault = 1'b0;
      pos_c = lane_code(pos, value_type'(active_limits.pos_low),
                        value_type'(active_limits.pos_high), POS_BITS, fault);
      spd_c = lane_code(spd, value_type'(active_limits.speed_low),
                        value_type'(active_limits.speed_high), CMD_BITS, fault);
      trq_c = lane_code(trq, value_type'(active_limits.torque_low),
                        value_type'(active_limits.torque_high), CMD_BITS, fault);
      kp_c  = lane_code(kp, '0, value_type'({1'b0, active_limits.stiff_high[GAIN_W-1:0]}),
                        CMD_BITS, fault);
      kd_c  = lane_code(kd, '0, value_type'({1'b0, active_limits.damp_high[GAIN_W-1:0]}),
                        CMD_BITS, fault);
      word.payload = {pos_c, spd_c[CMD_BITS-1:0], kp_c[CMD_BITS-1:0],
                      kd_c[CMD_BITS-1:0], trq_c[CMD_BITS-1:0]};
      word.fault   = fault;
      return word;
   endfunction

   // mostly in range, some on and just past the bounds, some anything at all
   function automatic value_type pick_value(input value_type lo, input value_type hi);
      longint          lo_l;
      longint          hi_l;
      longint unsigned span;
      int              roll;
      lo_l = longint'(lo);
      hi_l = longint'(hi);
      roll = $urandom_range(99);
      if (roll < 15 || hi_l <= lo_l) return $urandom;
      if (roll < 35) begin
         case ($urandom_range(5))
            0: return lo;
            1: return hi;
            2: return value_type'(lo_l - 1);
            3: return value_type'(hi_l + 1);
            4: return value_type'(lo_l + 1);
            default: return value_type'(hi_l - 1);
         endcase
      end
      span = hi_l - lo_l + 1;
      return value_type'(lo_l + ({$urandom, $urandom} % span));
   endfunction

   // signed range pair: empty, inverted, full, narrow or wide
   function automatic void pick_range(output logic [VAL_W-1:0] lo_word,
                                      output logic [VAL_W-1:0] hi_word);
      value_type a, b, center;
      int        roll;
      roll = $urandom_range(99);
      a = $urandom;
      b = $urandom;
      center = a >>> 2;
      if (roll < 10) begin
         lo_word = a;
         hi_word = a;
      end else if (roll < 20) begin
         lo_word = center;
         hi_word = center - $urandom_range(1, 300);
      end else if (roll < 30) begin
         lo_word = 32'h8000_0000;
         hi_word = 32'h7FFF_FFFF;
      end else if (roll < 55) begin
         lo_word = center;
         hi_word = center + $urandom_range(1, 4096);
      end else begin
         lo_word = (a < b) ? a : b;
         hi_word = (a < b) ? b : a;
      end
   endfunction

   // gain maximum word, bit 31 random since the block drops it
   function automatic logic [VAL_W-1:0] pick_gain();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return {1'($urandom), 31'd0};
      if (roll < 20) return {1'($urandom), 31'h7FFF_FFFF};
      if (roll < 50) return {1'($urandom), 31'($urandom_range(1, 4096))};
      return $urandom;
   endfunction

   // one csr transaction; valid stays high for the caller to lower
   task automatic write_register(input csr_index_type idx, input logic [VAL_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_writes++;
      case (idx)
         CSR_POSITION_LOW:   active_limits.pos_low     = value;
         CSR_POSITION_HIGH:  active_limits.pos_high    = value;
         CSR_SPEED_LOW:      active_limits.speed_low   = value;
         CSR_SPEED_HIGH:     active_limits.speed_high  = value;
         CSR_TORQUE_LOW:     active_limits.torque_low  = value;
         CSR_TORQUE_HIGH:    active_limits.torque_high = value;
         CSR_STIFFNESS_HIGH: active_limits.stiff_high  = value;
         CSR_DAMPING_HIGH:   active_limits.damp_high   = value;
         default: ;
      endcase
   endtask

   // stop sending and wait until every expected word has come back
   task automatic settle_pipeline();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   // write all range registers while the block is empty
   task automatic load_config(input limit_set_type ls);
      settle_pipeline();
      write_register(CSR_POSITION_LOW, ls.pos_low);
      write_register(CSR_POSITION_HIGH, ls.pos_high);
      write_register(CSR_SPEED_LOW, ls.speed_low);
      write_register(CSR_SPEED_HIGH, ls.speed_high);
      write_register(CSR_TORQUE_LOW, ls.torque_low);
      write_register(CSR_TORQUE_HIGH, ls.torque_high);
      write_register(CSR_STIFFNESS_HIGH, ls.stiff_high);
      write_register(CSR_DAMPING_HIGH, ls.damp_high);
      csr_valid <= 1'b0;
      range_sets++;
   endtask

   // one command transaction, with random idle cycles ahead of it
   task automatic send_command(input value_type pos, input value_type spd,
                               input value_type trq, input value_type kp,
                               input value_type kd);
      while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {kd, kp, trq, spd, pos};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_words.push_back(predict_command(pos, spd, trq, kp, kd));
      commands_sent++;
   endtask

   // values at the bounds of the reset ranges and of the fields
   task automatic test_default_ranges();
      send_command(0, 0, 0, 0, 0);
      send_command(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_command(POS_LOW_RESET, SPEED_LOW_RESET, TORQUE_LOW_RESET, 0, 0);
      send_command(POS_HIGH_RESET, SPEED_HIGH_RESET, TORQUE_HIGH_RESET,
                   {1'b0, STIFF_HIGH_RESET}, {1'b0, DAMP_HIGH_RESET});
      send_command(POS_LOW_RESET - 1, SPEED_HIGH_RESET + 1, TORQUE_LOW_RESET - 1,
                   STIFF_HIGH_RESET + 1, DAMP_HIGH_RESET + 1);
      // negative gains clamp to zero
      send_command(-1, -1, -1, -1, -65536);
      send_command(1, 32'h0001_2345, -32'sd77777, 32'h0032_1000, 32'h000A_0001);
   endtask

   // widest spans the registers allow
   task automatic test_extreme_ranges();
      limit_set_type ls;
      ls = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
      load_config(ls);
      send_command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
      send_command(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_command(0, -1, 1, 32'h4000_0000, 32'h3FFF_FFFF);
      send_command(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h8000_0000, 1);
   endtask

   // empty and inverted spans raise the fault, other lanes still pack
   task automatic test_empty_spans();
      limit_set_type ls;
      ls = '{32'h0001_0000, 32'h0001_0000, 32'h0000_0010, 32'h0000_000F,
             TORQUE_LOW_RESET, TORQUE_HIGH_RESET, 32'h0006_4000, 32'h0001_4000};
      load_config(ls);
      send_command(32'h0001_0000, 32'h0000_0010, 32'h0005_0000, 32'h0003_0000, 32'h0000_8000);
      send_command(32'h8000_0000, 32'h7FFF_FFFF, -1, -1, 32'h7FFF_FFFF);
      // gain maximum of zero, bit 31 set in the written word
      ls = '{POS_LOW_RESET, POS_HIGH_RESET, SPEED_LOW_RESET, SPEED_HIGH_RESET,
             32'h0000_0101, 32'h0000_0100, 32'h8000_0000, 32'h8000_0000};
      load_config(ls);
      send_command(32'h0000_4000, 32'h0003_0000, 32'h0000_0100, 0, 32'h0000_0001);
      send_command(POS_HIGH_RESET, SPEED_LOW_RESET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -1);
      // span of one step: only the ends give distinct codes
      ls = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0007, 32'h0000_0008,
             32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001};
      load_config(ls);
      send_command(-1, 7, 32'h7FFF_FFFE, 0, 0);
      send_command(0, 8, 32'h7FFF_FFFF, 1, 1);
      send_command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, -1);
   endtask

   // random range settings, each followed by a burst of random commands
   task automatic test_random_traffic();
      limit_set_type ls;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick_range(ls.pos_low, ls.pos_high);
         pick_range(ls.speed_low, ls.speed_high);
         pick_range(ls.torque_low, ls.torque_high);
         ls.stiff_high = pick_gain();
         ls.damp_high  = pick_gain();
         load_config(ls);
         // one phase runs with both sides streaming without gaps
         steady_run = (phase == RANDOM_PHASES / 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_command(pick_value(value_type'(active_limits.pos_low),
                                    value_type'(active_limits.pos_high)),
                         pick_value(value_type'(active_limits.speed_low),
                                    value_type'(active_limits.speed_high)),
                         pick_value(value_type'(active_limits.torque_low),
                                    value_type'(active_limits.torque_high)),
                         pick_value('0, value_type'({1'b0,
                                    active_limits.stiff_high[GAIN_W-1:0]})),
                         pick_value('0, value_type'({1'b0,
                                    active_limits.damp_high[GAIN_W-1:0]})));
         end
      end
      steady_run = 1'b0;
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // compare each returned command word with the oldest expected one
   always @(posedge clock) begin
      command_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected command word %h, range_fault %b", rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (rsp_tdata !== want.payload) begin
               $error("packed_payload mismatch: expected %h, actual %h",
                      want.payload, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.fault) begin
               $error("range_fault mismatch: expected %b, actual %b", want.fault, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_ranges();
      test_extreme_ranges();
      test_empty_spans();
      test_random_traffic();
      settle_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d commands under %0d range settings (%0d register writes)",
               commands_sent, range_sets, csr_writes);
      $display("checked %0d command words, %0d mismatches", words_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
